// ----- rtl/ddwsf_pkg.sv -----
// ----------------------------------------------------------------------------
// ddwsf_pkg
// Shared types and constants for the differential-drive wheel speed framer.
// ----------------------------------------------------------------------------
package ddwsf_pkg;

   // Field widths
   localparam int VelWidth   = 16;
   localparam int GainWidth  = 32;
   localparam int ProdWidth  = VelWidth + GainWidth + 1;  // signed v times unsigned gain
   localparam int SumWidth   = ProdWidth + 1;
   localparam int FracBits   = 26;                       // 10 input + 16 gain fraction bits
   localparam int SpeedWidth = 15;                       // saturates at 32767
   localparam int ByteWidth  = 8;

   // Frame layout
   localparam int FrameLen  = 10;
   localparam int IdxWidth  = $clog2(FrameLen);

   localparam logic [IdxWidth-1:0] IdxSync0     = IdxWidth'(0);
   localparam logic [IdxWidth-1:0] IdxSync1     = IdxWidth'(1);
   localparam logic [IdxWidth-1:0] IdxDirLeft   = IdxWidth'(2);
   localparam logic [IdxWidth-1:0] IdxDirRight  = IdxWidth'(3);
   localparam logic [IdxWidth-1:0] IdxLeftHi    = IdxWidth'(4);
   localparam logic [IdxWidth-1:0] IdxLeftLo    = IdxWidth'(5);
   localparam logic [IdxWidth-1:0] IdxRightHi   = IdxWidth'(6);
   localparam logic [IdxWidth-1:0] IdxRightLo   = IdxWidth'(7);
   localparam logic [IdxWidth-1:0] IdxTrail0    = IdxWidth'(8);
   localparam logic [IdxWidth-1:0] IdxTrail1    = IdxWidth'(9);

   localparam logic [ByteWidth-1:0] Sync0Byte  = 8'hA5;
   localparam logic [ByteWidth-1:0] Sync1Byte  = 8'hA6;
   localparam logic [ByteWidth-1:0] Trail0Byte = 8'h6B;
   localparam logic [ByteWidth-1:0] Trail1Byte = 8'h5B;

   // Configuration register indexes and reset values
   localparam logic CsrLinearGain  = 1'b0;
   localparam logic CsrAngularGain = 1'b1;

   localparam logic [GainWidth-1:0] LinearGainReset  = 32'd20860764;
   localparam logic [GainWidth-1:0] AngularGainReset = 32'd625822;

   // One wheel command, ready for framing
   typedef struct packed {
      logic                  left_rev;
      logic                  right_fwd;
      logic [SpeedWidth-1:0] left_rpm;
      logic [SpeedWidth-1:0] right_rpm;
   } wheel_cmd_type;

endpackage

// ----- rtl/ddwsf_kin.sv -----
// ----------------------------------------------------------------------------
// ddwsf_kin
// Inverse kinematics pipeline: input register, gain products, wheel sums,
// then magnitude, saturation and direction flags toward the framer.
// ----------------------------------------------------------------------------
module ddwsf_kin
   import ddwsf_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  logic [VelWidth-1:0]  linear_velocity,
   input  logic [VelWidth-1:0]  angular_velocity,
   input  logic [GainWidth-1:0] linear_gain,
   input  logic [GainWidth-1:0] angular_gain,
   output logic                 cmd_valid,
   input  logic                 cmd_ready,
   output wheel_cmd_type        cmd
);

   logic                       in_vld_ff;
   logic                       prod_vld_ff;
   logic                       sum_vld_ff;
   logic [VelWidth-1:0]        lin_ff;
   logic [VelWidth-1:0]        ang_ff;
   logic signed [ProdWidth-1:0] lin_prod_ff;
   logic signed [ProdWidth-1:0] ang_prod_ff;
   logic signed [SumWidth-1:0]  left_ff;
   logic signed [SumWidth-1:0]  right_ff;

   logic                       sum_move;
   logic                       prod_move;
   logic                       in_move;
   logic signed [ProdWidth-1:0] lin_prod_in;
   logic signed [ProdWidth-1:0] ang_prod_in;
   logic signed [SumWidth-1:0]  left_in;
   logic signed [SumWidth-1:0]  right_in;
   logic [SumWidth-1:0]        left_mag;
   logic [SumWidth-1:0]        right_mag;

   // Stall chain: a stage moves on when the one below is free or draining
   assign sum_move  = !sum_vld_ff  || cmd_ready;
   assign prod_move = !prod_vld_ff || sum_move;
   assign in_move   = !in_vld_ff   || prod_move;
   assign in_ready  = in_move;

   // Gain products, exact with 26 fraction bits
   assign lin_prod_in = $signed(lin_ff) * $signed({1'b0, linear_gain});
   assign ang_prod_in = $signed(ang_ff) * $signed({1'b0, angular_gain});

   // Wheel sums, left subtracts the yaw term
   assign left_in  = {lin_prod_ff[ProdWidth-1], lin_prod_ff}
                   - {ang_prod_ff[ProdWidth-1], ang_prod_ff};
   assign right_in = {lin_prod_ff[ProdWidth-1], lin_prod_ff}
                   + {ang_prod_ff[ProdWidth-1], ang_prod_ff};

   // Magnitude, truncate toward zero, saturate at full scale
   assign left_mag  = left_ff[SumWidth-1]  ? SumWidth'(-left_ff)  : SumWidth'(left_ff);
   assign right_mag = right_ff[SumWidth-1] ? SumWidth'(-right_ff) : SumWidth'(right_ff);

   always_comb begin
      cmd.left_rev  = left_ff[SumWidth-1];
      cmd.right_fwd = !right_ff[SumWidth-1];
      if (|left_mag[SumWidth-1:FracBits+SpeedWidth]) begin
         cmd.left_rpm = '1;
      end else begin
         cmd.left_rpm = left_mag[FracBits+SpeedWidth-1:FracBits];
      end
      if (|right_mag[SumWidth-1:FracBits+SpeedWidth]) begin
         cmd.right_rpm = '1;
      end else begin
         cmd.right_rpm = right_mag[FracBits+SpeedWidth-1:FracBits];
      end
   end

   assign cmd_valid = sum_vld_ff;

   // Valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff   <= 1'b0;
         prod_vld_ff <= 1'b0;
         sum_vld_ff  <= 1'b0;
      end else begin
         if (in_move)   in_vld_ff   <= in_valid;
         if (prod_move) prod_vld_ff <= in_vld_ff;
         if (sum_move)  sum_vld_ff  <= prod_vld_ff;
      end
   end

   // Payload stages
   always_ff @(posedge clock) begin
      if (in_move) begin
         lin_ff <= linear_velocity;
         ang_ff <= angular_velocity;
      end
      if (prod_move) begin
         lin_prod_ff <= lin_prod_in;
         ang_prod_ff <= ang_prod_in;
      end
      if (sum_move) begin
         left_ff  <= left_in;
         right_ff <= right_in;
      end
   end

endmodule

// ----- rtl/ddwsf_ser.sv -----
// ----------------------------------------------------------------------------
// ddwsf_ser
// Frame serializer: holds one wheel command and sends its ten frame bytes,
// one beat per cycle while out_ready is high, loading the next command on the last beat.
// ----------------------------------------------------------------------------
module ddwsf_ser
   import ddwsf_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 cmd_valid,
   output logic                 cmd_ready,
   input  wheel_cmd_type        cmd,
   output logic                 out_valid,
   input  logic                 out_ready,
   output logic [ByteWidth-1:0] out_byte,
   output logic                 out_last
);

   logic                busy_ff;
   logic [IdxWidth-1:0] idx_ff;
   wheel_cmd_type       cmd_ff;

   logic                beat;
   logic                last;

   assign last      = (idx_ff == IdxTrail1);
   assign beat      = busy_ff && out_ready;
   assign cmd_ready = !busy_ff || (beat && last);

   // Advance through the frame, reload at its end
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= IdxSync0;
      end else if (cmd_ready) begin
         busy_ff <= cmd_valid;
         idx_ff  <= IdxSync0;
      end else if (beat) begin
         idx_ff  <= idx_ff + IdxWidth'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_ready && cmd_valid) begin
         cmd_ff <= cmd;
      end
   end

   // Select the byte for the current position
   always_comb begin
      unique case (idx_ff)
         IdxSync0:    out_byte = Sync0Byte;
         IdxSync1:    out_byte = Sync1Byte;
         IdxDirLeft:  out_byte = ByteWidth'(cmd_ff.left_rev);
         IdxDirRight: out_byte = ByteWidth'(cmd_ff.right_fwd);
         IdxLeftHi:   out_byte = ByteWidth'(cmd_ff.left_rpm[SpeedWidth-1:ByteWidth]);
         IdxLeftLo:   out_byte = cmd_ff.left_rpm[ByteWidth-1:0];
         IdxRightHi:  out_byte = ByteWidth'(cmd_ff.right_rpm[SpeedWidth-1:ByteWidth]);
         IdxRightLo:  out_byte = cmd_ff.right_rpm[ByteWidth-1:0];
         IdxTrail0:   out_byte = Trail0Byte;
         IdxTrail1:   out_byte = Trail1Byte;
         default:     out_byte = '0;
      endcase
   end

   assign out_valid = busy_ff;
   assign out_last  = last;

   // Position never runs past the frame
   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      idx_ff <= IdxTrail1)
      else $error("frame position out of range");

   // A taken beat that is not the last steps to the next position
   a_idx_step: assert property (@(posedge clock) disable iff (reset)
      beat && !last |=> idx_ff == $past(idx_ff) + IdxWidth'(1))
      else $error("frame position did not advance");

   // A stalled beat keeps the position and the frame
   a_idx_hold: assert property (@(posedge clock) disable iff (reset)
      busy_ff && !out_ready |=> busy_ff && $stable(idx_ff) && $stable(cmd_ff))
      else $error("frame moved while stalled");

   // A loaded command starts at the first sync byte
   a_load_start: assert property (@(posedge clock) disable iff (reset)
      cmd_ready && cmd_valid |=> busy_ff && idx_ff == IdxSync0)
      else $error("new frame did not start at the sync byte");

endmodule

// ----- rtl/diff_drive_wheel_speed_framer.sv -----
// ----------------------------------------------------------------------------
// diff_drive_wheel_speed_framer
// Body velocity command to left and right wheel rpm, sent as a ten-byte
// motor frame.
// ----------------------------------------------------------------------------
// Each command beat (linear and angular velocity) yields ten frame beats,
// A5 A6 dirL dirR speedL_hi speedL_lo speedR_hi speedR_lo 6B 5B, with tlast
// on the last. The framer sends one byte per cycle while rsp_tready is high.
// Each command passes through the input register, product register, sum
// register and frame register before its first byte appears. Up to three
// further commands queue in the pipeline while a frame goes out. Gains are
// written through the csr port; the user must write them only while the
// block is idle, which the block itself does not enforce.
// ----------------------------------------------------------------------------
module diff_drive_wheel_speed_framer
   import ddwsf_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   // Command channel
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [31:0]          req_tdata,   // [15:0] linear_velocity, [31:16] angular_velocity
   // Frame channel
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [7:0]           rsp_tdata,   // [7:0] frame_byte
   output logic                 rsp_tlast,   // last_byte
   // Configuration
   input  logic                 csr_we,
   input  logic                 csr_addr,
   input  logic [GainWidth-1:0] csr_wdata
);

   logic [GainWidth-1:0] linear_gain_ff;
   logic [GainWidth-1:0] angular_gain_ff;
   logic                 cmd_valid;
   logic                 cmd_ready;
   wheel_cmd_type        cmd;

   // Gain registers
   always_ff @(posedge clock) begin
      if (reset) begin
         linear_gain_ff  <= LinearGainReset;
         angular_gain_ff <= AngularGainReset;
      end else if (csr_we) begin
         unique case (csr_addr)
            CsrLinearGain:  linear_gain_ff  <= csr_wdata;
            CsrAngularGain: angular_gain_ff <= csr_wdata;
            default:        ;
         endcase
      end
   end

   ddwsf_kin u_kin (
      .clock            (clock),
      .reset            (reset),
      .in_valid         (req_tvalid),
      .in_ready         (req_tready),
      .linear_velocity  (req_tdata[VelWidth-1:0]),
      .angular_velocity (req_tdata[2*VelWidth-1:VelWidth]),
      .linear_gain      (linear_gain_ff),
      .angular_gain     (angular_gain_ff),
      .cmd_valid        (cmd_valid),
      .cmd_ready        (cmd_ready),
      .cmd              (cmd)
   );

   ddwsf_ser u_ser (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .cmd       (cmd),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_byte  (rsp_tdata),
      .out_last  (rsp_tlast)
   );

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb - wheel speed framer testbench
// Sends body velocity commands and checks every ten-byte motor frame that
// comes back against a local prediction of the wheel kinematics. The gain
// registers are stepped through reset, zero, maximum, unit and random
// settings, with bursty command traffic and a stalling frame receiver.
// ----------------------------------------------------------------------------
module tb;
   import ddwsf_pkg::*;

   typedef struct packed {
      logic [ByteWidth-1:0] data;
      logic                 tail;
   } frame_beat_type;

   typedef enum logic [1:0] {RxOpen, RxCoin, RxSparse, RxComb} rx_mode_type;

   // Predicts frame bytes from the gains and holds them until they arrive
   class wheel_frame_board;
      logic [GainWidth-1:0] linear_gain;
      logic [GainWidth-1:0] angular_gain;
      frame_beat_type       due_beats[$];
      int unsigned          mismatches;
      int unsigned          commands;
      int unsigned          beats;

      function new();
         linear_gain  = LinearGainReset;
         angular_gain = AngularGainReset;
         mismatches   = 0;
         commands     = 0;
         beats        = 0;
      endfunction

      function void set_gain(logic idx, logic [GainWidth-1:0] value);
         if (idx == CsrLinearGain) begin
            linear_gain = value;
         end else begin
            angular_gain = value;
         end
      endfunction

      // Truncate the magnitude toward zero and clamp at full scale
      function logic [SpeedWidth-1:0] wheel_rpm(longint sum);
         longint unsigned mag;
         mag = (sum < 0) ? longint'(-sum) : longint'(sum);
         mag = mag >> FracBits;
         return (mag > 64'd32767) ? 15'h7FFF : mag[SpeedWidth-1:0];
      endfunction

      function void push_beat(logic [ByteWidth-1:0] data, logic tail);
         frame_beat_type beat;
         beat.data = data;
         beat.tail = tail;
         due_beats.push_back(beat);
      endfunction

      function void note_command(logic signed [VelWidth-1:0] v,
                                 logic signed [VelWidth-1:0] w);
         longint                lin;
         longint                ang;
         longint                left;
         longint                right;
         logic [15:0]           rpm_l;
         logic [15:0]           rpm_r;
         lin   = longint'(v) * longint'({32'b0, linear_gain});
         ang   = longint'(w) * longint'({32'b0, angular_gain});
         left  = lin - ang;
         right = lin + ang;
         rpm_l = {1'b0, wheel_rpm(left)};
         rpm_r = {1'b0, wheel_rpm(right)};
         commands++;
         push_beat(Sync0Byte, 1'b0);
         push_beat(Sync1Byte, 1'b0);
         // left motor flags reverse; right motor is mirrored
         push_beat((left < 0) ? 8'd1 : 8'd0, 1'b0);
         push_beat((right >= 0) ? 8'd1 : 8'd0, 1'b0);
         push_beat(rpm_l[15:8], 1'b0);
         push_beat(rpm_l[7:0], 1'b0);
         push_beat(rpm_r[15:8], 1'b0);
         push_beat(rpm_r[7:0], 1'b0);
         push_beat(Trail0Byte, 1'b0);
         push_beat(Trail1Byte, 1'b1);
      endfunction

      function void check_beat(logic [ByteWidth-1:0] data, logic tail);
         frame_beat_type due;
         beats++;
         if (due_beats.size() == 0) begin
            $error("frame beat with no command pending: frame_byte %02h last_byte %b",
                   data, tail);
            mismatches++;
         end else begin
            due = due_beats.pop_front();
            if (data !== due.data) begin
               $error("frame_byte mismatch: expected %02h, actual %02h", due.data, data);
               mismatches++;
            end
            if (tail !== due.tail) begin
               $error("last_byte mismatch: expected %b, actual %b", due.tail, tail);
               mismatches++;
            end
         end
      endfunction

      function int pending();
         return due_beats.size();
      endfunction
   endclass

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [31:0]          req_tdata = '0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [7:0]           rsp_tdata;
   logic                 rsp_tlast;
   logic                 csr_we = 1'b0;
   logic                 csr_addr = 1'b0;
   logic [GainWidth-1:0] csr_wdata = '0;

   wheel_frame_board board = new();
   int unsigned      burst_left = 0;
   int unsigned      gain_writes = 0;
   rx_mode_type      rx_mode = RxOpen;
   int unsigned      rx_left = 0;
   int unsigned      rx_tick = 0;

   diff_drive_wheel_speed_framer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   // 20 ns clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Stall the frame receiver in changing patterns
   always @(negedge clock) begin
      if (rx_left == 0) begin
         rx_mode = rx_mode_type'($urandom_range(0, 3));
         rx_left = $urandom_range(20, 120);
      end
      rx_left--;
      rx_tick++;
      case (rx_mode)
         RxOpen: begin
            rsp_tready <= 1'b1;
         end
         RxCoin: begin
            rsp_tready <= 1'($urandom_range(0, 1));
         end
         RxSparse: begin
            rsp_tready <= ($urandom_range(0, 3) == 0);
         end
         default: begin
            rsp_tready <= (rx_tick % 3 != 0);
         end
      endcase
   end

   // Check each accepted frame beat
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         board.check_beat(rsp_tdata, rsp_tlast);
      end
   end

   // Full-range values half the time, with small, medium and extreme ones mixed in
   function automatic logic signed [VelWidth-1:0] rand_vel();
      int pick;
      pick = $urandom_range(0, 5);
      case (pick)
         0, 1, 2: return 16'($urandom_range(0, 65535));
         3:       return $signed(16'($urandom_range(0, 127))) - 16'sd64;
         4: begin
            case ($urandom_range(0, 4))
               0:       return -16'sd32768;
               1:       return 16'sd32767;
               2:       return 16'sd0;
               3:       return -16'sd1;
               default: return 16'sd1;
            endcase
         end
         default: return $signed(16'($urandom_range(0, 8191))) - 16'sd4096;
      endcase
   endfunction

   // Send one command beat, idling between bursts
   task automatic send_command(logic signed [VelWidth-1:0] v,
                               logic signed [VelWidth-1:0] w);
      int unsigned gap;
      if (burst_left == 0) begin
         gap = $urandom_range(1, 6);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                  : $urandom_range(1, 10);
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= {w, v};
      do @(posedge clock); while (req_tready !== 1'b1);
      board.note_command(v, w);
      burst_left--;
   endtask

   // Hold off until every frame is out and the pipeline has settled
   task automatic drain_frames();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_gain(logic idx, logic [GainWidth-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      board.set_gain(idx, value);
      gain_writes++;
   endtask

   task automatic set_gains(logic [GainWidth-1:0] lin, logic [GainWidth-1:0] ang);
      drain_frames();
      write_gain(CsrLinearGain, lin);
      write_gain(CsrAngularGain, ang);
   endtask

   task automatic run_random(int count);
      for (int i = 0; i < count; i++) begin
         send_command(rand_vel(), rand_vel());
         if ($urandom_range(0, 39) == 0) begin
            drain_frames();
         end
      end
   endtask

   // Run ends here if the block hangs
   initial begin
      #5000000;
      $display("Verification failed");
      $finish;
   end

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset gains: field extremes, sign combinations, tiny negative sums
      send_command(16'sd0, 16'sd0);
      send_command(16'sd32767, 16'sd0);
      send_command(-16'sd32768, 16'sd0);
      send_command(16'sd0, 16'sd32767);
      send_command(16'sd0, -16'sd32768);
      send_command(16'sd32767, 16'sd32767);
      send_command(-16'sd32768, -16'sd32768);
      send_command(16'sd32767, -16'sd32768);
      send_command(-16'sd32768, 16'sd32767);
      send_command(-16'sd1, 16'sd0);
      send_command(16'sd0, 16'sd1);
      run_random(110);

      // Zero gains: every speed zero, flags from sign of zero sums
      set_gains('0, '0);
      send_command(-16'sd32768, 16'sd32767);
      send_command(-16'sd1, -16'sd1);
      run_random(30);

      // Maximum gains: saturation on both wheels
      set_gains('1, '1);
      send_command(16'sd32767, -16'sd32768);
      send_command(-16'sd1, 16'sd0);
      send_command(16'sd1, -16'sd1);
      run_random(60);

      // Unit gains: speed equals the velocity sum, clamp edge at 32768
      set_gains(32'h0400_0000, 32'h0400_0000);
      send_command(-16'sd32768, 16'sd0);
      send_command(16'sd32767, 16'sd0);
      send_command(16'sd0, -16'sd32768);
      send_command(16'sd7, 16'sd7);
      send_command(-16'sd7, 16'sd7);
      run_random(90);

      // Random gains, full range and then small against large
      set_gains($urandom(), $urandom());
      run_random(90);
      set_gains($urandom_range(0, 32'h0800_0000), $urandom());
      run_random(80);

      drain_frames();
      $display("Covered %0d commands and %0d frame beats over %0d gain writes.",
               board.commands, board.beats, gain_writes);
      $display("Gain settings: reset, zero, maximum, unit and random.");
      if (board.mismatches == 0 && board.pending() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
